[sv/b64e_pkg.sv]
// shared types, constants and the sextet-to-character lookup for the base64 encoder
`timescale 1ns / 1ps
package b64e_pkg;

  // ascii codes used by the alphabet and padding
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  // sextet range limits
  localparam logic [5:0] SEXTET_LAST_UPPER = 6'd25;
  localparam logic [5:0] SEXTET_LAST_LOWER = 6'd51;
  localparam logic [5:0] SEXTET_LAST_DIGIT = 6'd61;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;

  localparam int SLOTS = 4;

  // one output character slot: pad marker or data sextet
  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } b64e_slot_t;

  // work for one byte: up to four characters, index of the final one
  typedef struct packed {
    b64e_slot_t [SLOTS-1:0] slot;
    logic [1:0]             last_idx;
    logic                   last;
  } b64e_cmd_t;

  // map a sextet to its alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v <= SEXTET_LAST_UPPER) begin
      ch = CHAR_UPPER_A + {2'b00, v};
    end else if (v <= SEXTET_LAST_LOWER) begin
      ch = CHAR_LOWER_A + {2'b00, v - SEXTET_LOWER_BASE};
    end else if (v <= SEXTET_LAST_DIGIT) begin
      ch = CHAR_DIGIT_0 + {2'b00, v - SEXTET_DIGIT_BASE};
    end else if (v == SEXTET_PLUS) begin
      ch = CHAR_PLUS;
    end else begin
      ch = CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage

[sv/base64_stream_encoder.sv]
// top level of the streaming padded base64 encoder
//
//   channel | signals                         | direction | word
//   --------+---------------------------------+-----------+---------------------------
//   in      | in_valid in_ready data_byte     | sink      | one message byte + last
//           | last_byte                       |           |
//   out     | out_valid out_ready out_char    | source    | one character + last flag
//           | last_char                       |           |
//
// a byte is taken every cycle while the command queue has room; each byte makes
// 1 to 4 characters, and the back end sends one character per cycle while out_ready
// is high, so the sustained rate is set by that output stage. a byte is written into
// the queue, then loaded into the back end command register, before its first character
// goes out. synchronous reset clears group phase, carry, queue and back end state.
// an output stall fills the queue, then drops in_ready.
`timescale 1ns / 1ps
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_char,
  output logic       last_char,
  output logic       out_valid,
  input  logic       out_ready
);
  import b64e_pkg::*;

  b64e_cmd_t push_cmd, head_cmd;
  logic      q_push, q_full, q_pop, q_not_empty;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_char    (out_char),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

[sv/b64e_front.sv]
// front end: tracks group phase and carry bits, turns each byte into a character command
`timescale 1ns / 1ps
module b64e_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 q_full,
  output logic                 q_push,
  output b64e_pkg::b64e_cmd_t  q_cmd
);
  import b64e_pkg::*;

  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [5:0] carry, carry_next;
  logic [5:0] new_carry;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // classify the word by phase and build its command
  always_comb begin
    q_cmd      = '0;
    q_cmd.last = last_byte;
    new_carry  = '0;
    case (phase)
      PH1: begin
        q_cmd.slot[0].sextet = carry | {2'b00, data_byte[7:4]};
        new_carry            = {data_byte[3:0], 2'b00};
        phase_next           = PH2;
        if (last_byte) begin
          q_cmd.slot[1].sextet = new_carry;
          q_cmd.slot[2].pad    = 1'b1;
          q_cmd.last_idx       = 2'd2;
        end
      end
      PH2: begin
        q_cmd.slot[0].sextet = carry | {4'b0000, data_byte[7:6]};
        q_cmd.slot[1].sextet = data_byte[5:0];
        q_cmd.last_idx       = 2'd1;
        phase_next           = PH0;
      end
      default: begin
        q_cmd.slot[0].sextet = data_byte[7:2];
        new_carry            = {data_byte[1:0], 4'b0000};
        phase_next           = PH1;
        if (last_byte) begin
          q_cmd.slot[1].sextet = new_carry;
          q_cmd.slot[2].pad    = 1'b1;
          q_cmd.slot[3].pad    = 1'b1;
          q_cmd.last_idx       = 2'd3;
        end
      end
    endcase
    carry_next = new_carry;
    // end of message restarts the group
    if (last_byte) begin
      phase_next = PH0;
      carry_next = '0;
    end
  end

  // phase and carry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH0;
      carry <= '0;
    end else if (q_push) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

[sv/b64e_queue.sv]
// small show-ahead queue of character commands between front and back
`timescale 1ns / 1ps
module b64e_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  b64e_pkg::b64e_cmd_t  push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output b64e_pkg::b64e_cmd_t  head_cmd
);
  import b64e_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_cmd_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");

endmodule

[sv/b64e_back.sv]
// back end: steps through the characters of each command, one per cycle while out_ready is high
`timescale 1ns / 1ps
module b64e_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  b64e_pkg::b64e_cmd_t  q_cmd,
  output logic                 q_pop,
  output logic [7:0]           out_char,
  output logic                 last_char,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import b64e_pkg::*;

  b64e_cmd_t  cmd;
  logic       cmd_valid;
  logic [1:0] idx;
  logic       cmd_done;
  b64e_slot_t cur;

  assign cur       = cmd.slot[idx];
  assign out_valid = cmd_valid;
  assign out_char  = cur.pad ? CHAR_PAD : sextet_char(cur.sextet);
  assign last_char = cmd.last && (idx == cmd.last_idx);

  // final character of the held command goes out this cycle
  assign cmd_done = cmd_valid && out_ready && (idx == cmd.last_idx);
  assign q_pop    = q_not_empty && (!cmd_valid || cmd_done);

  // command register and character index
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cmd_valid <= 1'b1;
      idx       <= '0;
    end else if (cmd_done) begin
      cmd_valid <= 1'b0;
      idx       <= '0;
    end else if (cmd_valid && out_ready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> idx <= cmd.last_idx)
    else $error("character index past end of command");

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !out_ready |=> cmd_valid && idx == $past(idx))
    else $error("character index moved while stalled");

  a_last_only_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_char |-> cmd.last && idx == cmd.last_idx)
    else $error("last flag on a non-final character");

endmodule

[test/tb_base64_stream_encoder.sv]
// self-checking testbench for the streaming padded base64 encoder
`timescale 1ns / 1ps
module tb_base64_stream_encoder;
  import b64e_pkg::CHAR_PAD;

  // one message byte waiting to be sent
  typedef struct {
    logic [7:0] data;
    logic       fin;
  } msg_byte_t;

  // one encoded character the block should produce
  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] out_char;
  logic       last_char;
  logic       out_valid;
  logic       out_ready = 1'b0;

  msg_byte_t byte_q[$];
  enc_char_t char_q[$];
  int        errors = 0;
  logic      in_took = 1'b0;

  // encoder state as predicted from accepted bytes
  logic [1:0] grp_phase = 2'd0;
  logic [5:0] carry = 6'd0;

  base64_stream_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_char  (out_char),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // no idling once the tail of the stimulus is reached
  function automatic logic quiet_tail();
    return byte_q.size() < 15;
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    string alphabet;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return alphabet[v];
  endfunction

  // work out the characters one byte releases and queue them
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] chars [4];
    int n;
    n = 0;
    case (grp_phase)
      2'd1: begin
        chars[0] = alphabet_char(carry | {2'b00, b[7:4]});
        carry = {b[3:0], 2'b00};
        grp_phase = 2'd2;
        n = 1;
        if (fin) begin
          chars[1] = alphabet_char(carry);
          chars[2] = CHAR_PAD;
          n = 3;
        end
      end
      2'd2: begin
        chars[0] = alphabet_char(carry | {4'b0000, b[7:6]});
        chars[1] = alphabet_char(b[5:0]);
        carry = 6'd0;
        grp_phase = 2'd0;
        n = 2;
      end
      default: begin
        // start of a group; the unused phase code behaves the same
        chars[0] = alphabet_char(b[7:2]);
        carry = {b[1:0], 4'b0000};
        grp_phase = 2'd1;
        n = 1;
        if (fin) begin
          chars[1] = alphabet_char(carry);
          chars[2] = CHAR_PAD;
          chars[3] = CHAR_PAD;
          n = 4;
        end
      end
    endcase
    if (fin) begin
      grp_phase = 2'd0;
      carry = 6'd0;
    end
    for (int k = 0; k < n; k++) begin
      char_q.push_back('{ch: chars[k], fin: fin && (k == n - 1)});
    end
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic fin);
    byte_q.push_back('{data: data, fin: fin});
  endtask

  // input driver: holds each word until taken, with random gap bursts
  int in_gap = 0;
  always @(negedge clk) begin
    msg_byte_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap == 0 && !quiet_tail() && $urandom_range(0, 4) == 0) begin
        in_gap = $urandom_range(1, 4);
      end
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (byte_q.size() > 0) begin
        item = byte_q.pop_front();
        data_byte <= item.data;
        last_byte <= item.fin;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure in random stall bursts
  int out_stall = 0;
  always @(negedge clk) begin
    if (out_stall == 0 && !quiet_tail() && $urandom_range(0, 4) == 0) begin
      out_stall = $urandom_range(1, 4);
    end
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on accepted bytes, check accepted characters
  always @(posedge clk) begin
    enc_char_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        encode_byte(data_byte, last_byte);
      end
      if (out_valid && out_ready) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected word out_char %h last_char %b", $time, out_char,
                   last_char);
          errors++;
        end else begin
          want = char_q.pop_front();
          if (out_char !== want.ch) begin
            $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
            errors++;
          end
          if (last_char !== want.fin) begin
            $display("%0t: last_char expected %b got %b", $time, want.fin, last_char);
            errors++;
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int len;
    // single-byte messages, padding with two pad characters
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // two-byte message, one pad character
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    // full groups, no padding
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b1);
    // plus and slash characters
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // message spanning two groups
    queue_byte(8'h14, 1'b0);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'h9C, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'hD9, 1'b0);
    queue_byte(8'h7E, 1'b1);
    // random messages of random length and content
    while (byte_q.size() < 95) begin
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        queue_byte(8'($urandom_range(0, 255)), k == len - 1);
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || in_valid || char_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);

    if (errors == 0 && char_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
